>>> sv/slle_pkg.sv
// ----------------------------------------------------------------------------
// slle_pkg
// Shared constants, types and helpers for the sorted linked list engine.
// ----------------------------------------------------------------------------
package slle_pkg;

  localparam int unsigned POOL_SLOTS = 64;
  localparam int unsigned KEY_BITS   = 32;

  localparam int unsigned IDX_W  = $clog2(POOL_SLOTS);
  localparam int unsigned LNK_W  = IDX_W + 1;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned CNT_W  = LNK_W;

  localparam int unsigned IN_DATA_W  = ((KEY_BITS + 7) / 8) * 8;
  localparam int unsigned IN_USER_W  = FUNC_W;
  localparam int unsigned OUT_BITS   = 1 + IDX_W + CNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [LNK_W-1:0] NIL = LNK_W'(POOL_SLOTS);

  localparam logic [FUNC_W-1:0] OP_SEARCH = 3'd0;
  localparam logic [FUNC_W-1:0] OP_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] OP_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] OP_SIZE   = 3'd3;
  localparam logic [FUNC_W-1:0] OP_CLEAR  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_ACT,
    ST_DEL1,
    ST_DEL2,
    ST_INS1,
    ST_INS2,
    ST_INS3,
    ST_FIN
  } state_e;

  function automatic logic is_slot(input logic [LNK_W-1:0] v);
    return v < NIL;
  endfunction

endpackage

>>> sv/sorted_linked_list_engine_unit.sv
// ----------------------------------------------------------------------------
// sorted_linked_list_engine_unit
// Sorted list of signed keys in a fixed slot pool with a free chain.
// ----------------------------------------------------------------------------
// Each transaction on the input stream is one request (search, insert,
// delete, size, clear) and yields exactly one result transaction. Keys and
// next links live in two single-port-read memories with registered reads;
// a request walks the sorted chain one slot per cycle, because each link
// read must return before the next address is known. Search, delete and
// insert visit at most 64 slots; size, clear and unknown requests skip
// the walk. One request is in work at a time; a finished result sits in
// an output register so the next request is accepted while it waits to be
// taken.
// Reset and clear need no sweep: link entries carry valid bits.
// ----------------------------------------------------------------------------
module sorted_linked_list_engine_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // key [KEY_BITS-1:0]
  input  logic [slle_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // func [2:0]
  input  logic [slle_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // ok [0], slot [IDX_W:1], count [above slot]
  output logic [slle_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import slle_pkg::*;

  // memories
  logic [KEY_BITS-1:0] key_mem [POOL_SLOTS];
  logic [LNK_W-1:0]    link_mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] vld_q;

  logic                key_we;
  logic [IDX_W-1:0]    key_wa;
  logic                link_we;
  logic [IDX_W-1:0]    link_wa;
  logic [LNK_W-1:0]    link_wd;
  logic                clr_vld;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    rd_addr_q;
  logic                rd_vld_q;
  logic [KEY_BITS-1:0] key_rd;
  logic [LNK_W-1:0]    link_rd;
  logic [LNK_W-1:0]    link_eff;
  logic [KEY_BITS-1:0] s_key_q, s_key_d;

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_wa] <= s_key_q;
    end
    key_rd <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd <= link_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_addr_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_addr_q <= rd_addr;
      rd_vld_q  <= vld_q[rd_addr];
      if (clr_vld) begin
        vld_q <= '0;
      end else if (link_we) begin
        vld_q[link_wa] <= 1'b1;
      end
    end
  end

  assign link_eff = rd_vld_q ? link_rd : ({1'b0, rd_addr_q} + LNK_W'(1));

  // control state
  state_e              state_q, state_d;
  logic [FUNC_W-1:0]   func_q, func_d;
  logic [LNK_W-1:0]    list_head_q, list_head_d;
  logic [LNK_W-1:0]    free_head_q, free_head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [LNK_W-1:0]    cur_q, cur_d;
  logic [LNK_W-1:0]    prev_q, prev_d;
  logic [LNK_W-1:0]    prev_link_q, prev_link_d;
  logic [LNK_W-1:0]    cur_link_q, cur_link_d;
  logic [LNK_W-1:0]    fresh_q, fresh_d;
  logic [LNK_W-1:0]    steps_q, steps_d;
  logic                found_q, found_d;
  logic                res_ok_q, res_ok_d;
  logic [IDX_W-1:0]    res_slot_q, res_slot_d;
  logic                m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                out_load;
  logic                out_free;
  logic                in_acc;
  logic                key_lt;
  logic                key_eq;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign key_lt        = $signed(key_rd) < $signed(s_key_q);
  assign key_eq        = key_rd == s_key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      list_head_q <= NIL;
      free_head_q <= '0;
      count_q     <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      list_head_q <= list_head_d;
      free_head_q <= free_head_d;
      count_q     <= count_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    s_key_q     <= s_key_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    prev_link_q <= prev_link_d;
    cur_link_q  <= cur_link_d;
    fresh_q     <= fresh_d;
    steps_q     <= steps_d;
    found_q     <= found_d;
    res_ok_q    <= res_ok_d;
    res_slot_q  <= res_slot_d;
    if (out_load) begin
      m_data_q <= OUT_DATA_W'({count_q, res_slot_q, res_ok_q});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    s_key_d     = s_key_q;
    list_head_d = list_head_q;
    free_head_d = free_head_q;
    count_d     = count_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    prev_link_d = prev_link_q;
    cur_link_d  = cur_link_q;
    fresh_d     = fresh_q;
    steps_d     = steps_q;
    found_d     = found_q;
    res_ok_d    = res_ok_q;
    res_slot_d  = res_slot_q;
    key_we      = 1'b0;
    key_wa      = '0;
    link_we     = 1'b0;
    link_wa     = '0;
    link_wd     = '0;
    clr_vld     = 1'b0;
    rd_addr     = '0;
    out_load    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          func_d     = s_axis_tuser[FUNC_W-1:0];
          s_key_d    = s_axis_tdata[KEY_BITS-1:0];
          res_ok_d   = 1'b0;
          res_slot_d = '0;
          cur_d      = NIL;
          prev_d     = NIL;
          steps_d    = '0;
          found_d    = 1'b0;
          state_d    = ST_FIN;
          case (s_axis_tuser[FUNC_W-1:0])
            OP_SEARCH, OP_INSERT, OP_DELETE: begin
              if (s_axis_tuser[FUNC_W-1:0] == OP_INSERT && !is_slot(free_head_q)) begin
                state_d = ST_FIN;
              end else if (is_slot(list_head_q)) begin
                rd_addr = list_head_q[IDX_W-1:0];
                cur_d   = list_head_q;
                state_d = ST_WALK;
              end else begin
                state_d = ST_ACT;
              end
            end
            OP_SIZE: begin
              res_ok_d = 1'b1;
            end
            OP_CLEAR: begin
              clr_vld     = 1'b1;
              list_head_d = NIL;
              free_head_d = '0;
              count_d     = '0;
              res_ok_d    = 1'b1;
            end
            default: begin
              res_ok_d = 1'b0;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (key_lt) begin
          prev_d      = cur_q;
          prev_link_d = link_eff;
          steps_d     = steps_q + LNK_W'(1);
          if (is_slot(link_eff) && (steps_q + LNK_W'(1)) != NIL) begin
            cur_d   = link_eff;
            rd_addr = link_eff[IDX_W-1:0];
          end else begin
            cur_d   = NIL;
            found_d = 1'b0;
            state_d = ST_ACT;
          end
        end else begin
          found_d    = key_eq;
          cur_link_d = link_eff;
          state_d    = ST_ACT;
        end
      end

      ST_ACT: begin
        state_d = ST_FIN;
        case (func_q)
          OP_SEARCH: begin
            res_ok_d   = found_q;
            res_slot_d = found_q ? cur_q[IDX_W-1:0] : '0;
          end
          OP_DELETE: begin
            if (found_q) begin
              state_d = ST_DEL1;
            end
          end
          OP_INSERT: begin
            if (!found_q) begin
              state_d = ST_INS1;
            end
          end
          default: begin
            state_d = ST_FIN;
          end
        endcase
      end

      ST_DEL1: begin
        if (is_slot(prev_q)) begin
          link_we = 1'b1;
          link_wa = prev_q[IDX_W-1:0];
          link_wd = cur_link_q;
        end else begin
          list_head_d = cur_link_q;
        end
        state_d = ST_DEL2;
      end

      ST_DEL2: begin
        link_we     = 1'b1;
        link_wa     = cur_q[IDX_W-1:0];
        link_wd     = free_head_q;
        free_head_d = cur_q;
        if (count_q != '0) begin
          count_d = count_q - CNT_W'(1);
        end
        res_ok_d = 1'b1;
        state_d  = ST_FIN;
      end

      ST_INS1: begin
        fresh_d = free_head_q;
        rd_addr = free_head_q[IDX_W-1:0];
        key_we  = 1'b1;
        key_wa  = free_head_q[IDX_W-1:0];
        state_d = ST_INS2;
      end

      ST_INS2: begin
        free_head_d = link_eff;
        link_we     = 1'b1;
        link_wa     = fresh_q[IDX_W-1:0];
        link_wd     = is_slot(prev_q) ? prev_link_q : list_head_q;
        state_d     = ST_INS3;
      end

      ST_INS3: begin
        if (is_slot(prev_q)) begin
          link_we = 1'b1;
          link_wa = prev_q[IDX_W-1:0];
          link_wd = fresh_q;
        end else begin
          list_head_d = fresh_q;
        end
        count_d    = count_q + CNT_W'(1);
        res_ok_d   = 1'b1;
        res_slot_d = fresh_q[IDX_W-1:0];
        state_d    = ST_FIN;
      end

      ST_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(POOL_SLOTS))
    else $error("entry count above pool size");

  a_free_empty_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !is_slot(free_head_q)) |-> count_q == CNT_W'(POOL_SLOTS))
    else $error("free chain empty while pool not full");

  a_list_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !is_slot(list_head_q)) |-> count_q == '0)
    else $error("list empty with nonzero count");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> steps_q < NIL)
    else $error("walk ran past pool size");

endmodule
